[src/cbrf_pkg.sv]
// ----------------------------------------------------------------------------
// cbrf_pkg
// Shared types, constants and helpers for the cubic bisection root finder.
// ----------------------------------------------------------------------------
package cbrf_pkg;

  localparam int FRAC_BITS      = 16;
  localparam int WORD_BITS      = 32;
  localparam int PROD_BITS      = 2 * WORD_BITS;
  localparam int TOL_BITS       = 31;
  localparam int STEP_BITS      = 6;
  localparam int STATUS_BITS    = 2;
  localparam int REG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 32;

  localparam logic [REG_INDEX_BITS-1:0] REG_COEF_CUBIC  = 3'd0;
  localparam logic [REG_INDEX_BITS-1:0] REG_COEF_SQUARE = 3'd1;
  localparam logic [REG_INDEX_BITS-1:0] REG_COEF_LINEAR = 3'd2;
  localparam logic [REG_INDEX_BITS-1:0] REG_COEF_CONST  = 3'd3;
  localparam logic [REG_INDEX_BITS-1:0] REG_TOLERANCE   = 3'd4;

  localparam logic [STATUS_BITS-1:0] STATUS_CONVERGED = 2'd0;
  localparam logic [STATUS_BITS-1:0] STATUS_EXACT     = 2'd1;
  localparam logic [STATUS_BITS-1:0] STATUS_NO_CHANGE = 2'd2;

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic signed [PROD_BITS-1:0] prod_t;

  typedef struct packed {
    word_t cubic;
    word_t square;
    word_t linear;
    word_t cnst;
  } coef_t;

  typedef struct packed {
    logic zero;
    logic neg;
  } sign_t;

  localparam word_t WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam word_t WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

  function automatic word_t sat_word(input prod_t v);
    prod_t hi;
    prod_t lo;
    hi = PROD_BITS'(WORD_MAX);
    lo = PROD_BITS'(WORD_MIN);
    if (v > hi) begin
      return WORD_MAX;
    end else if (v < lo) begin
      return WORD_MIN;
    end
    return v[WORD_BITS-1:0];
  endfunction

  function automatic prod_t ext_word(input word_t v);
    return {{(PROD_BITS-WORD_BITS){v[WORD_BITS-1]}}, v};
  endfunction

endpackage

[src/cbrf_regs.sv]
// ----------------------------------------------------------------------------
// cbrf_regs
// Configuration registers: cubic coefficients and halving tolerance.
// ----------------------------------------------------------------------------
module cbrf_regs import cbrf_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [REG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  output coef_t                     coef,
  output logic [TOL_BITS-1:0]       tol
);

  always_ff @(posedge clk) begin
    if (rst) begin
      coef.cubic  <= word_t'(65536);
      coef.square <= word_t'(-13107);
      coef.linear <= word_t'(32768);
      coef.cnst   <= word_t'(-65536);
      tol         <= TOL_BITS'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_COEF_CUBIC:  coef.cubic  <= cfg_data[WORD_BITS-1:0];
        REG_COEF_SQUARE: coef.square <= cfg_data[WORD_BITS-1:0];
        REG_COEF_LINEAR: coef.linear <= cfg_data[WORD_BITS-1:0];
        REG_COEF_CONST:  coef.cnst   <= cfg_data[WORD_BITS-1:0];
        REG_TOLERANCE:   tol         <= cfg_data[TOL_BITS-1:0];
        default: ;
      endcase
    end
  end

endmodule

[src/cbrf_eval.sv]
// ----------------------------------------------------------------------------
// cbrf_eval
// Horner evaluation of the cubic on one shared multiplier; reports the sign.
// Each pass: multiply, then shift, saturate, add coefficient, saturate.
// ----------------------------------------------------------------------------
module cbrf_eval import cbrf_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  word_t x,
  input  coef_t coef,
  output logic  done,
  output sign_t sign
);

  logic        busy;
  logic        phase;
  logic [1:0]  idx;
  word_t       xr;
  word_t       acc;
  prod_t       prod;
  prod_t       mul;
  word_t       prod_sat;
  word_t       addend;
  word_t       sum_sat;

  assign mul      = acc * xr;
  assign prod_sat = sat_word(prod >>> FRAC_BITS);

  always_comb begin
    case (idx)
      2'd0:    addend = coef.square;
      2'd1:    addend = coef.linear;
      default: addend = coef.cnst;
    endcase
  end

  assign sum_sat   = sat_word(ext_word(prod_sat) + ext_word(addend));
  assign sign.zero = (acc == '0);
  assign sign.neg  = acc[WORD_BITS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      phase <= 1'b0;
      idx   <= '0;
    end else begin
      done <= !start && busy && phase && (idx == 2'd2);
      if (start) begin
        busy  <= 1'b1;
        phase <= 1'b0;
        idx   <= '0;
      end else if (busy) begin
        if (!phase) begin
          phase <= 1'b1;
        end else begin
          phase <= 1'b0;
          idx   <= idx + 2'd1;
          if (idx == 2'd2) begin
            busy <= 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      xr  <= x;
      acc <= coef.cubic;
    end else if (busy) begin
      if (!phase) begin
        prod <= mul;
      end else begin
        acc <= sum_sat;
      end
    end
  end

endmodule

[src/cubic_bisection_root_finder_top.sv]
// ----------------------------------------------------------------------------
// cubic_bisection_root_finder_top
// Bisection root search of a configurable Q16.16 cubic over an input interval.
// ----------------------------------------------------------------------------
// One item at a time. An evaluation of the cubic runs from its launch through
// three Horner passes through the single 32x32 multiplier, each a multiply
// and then a shift, saturate and add, to done and the sign being seen. Each
// halving step adds an interval check before the evaluation at the midpoint.
// Both ends are evaluated first; an interval without a sign change finishes
// there, and an exact zero at a midpoint ends the search. The input is ready
// only while the sequencer is idle; a finished result sits in the output
// register and does not block the next input beat, but the next result waits
// until that one is taken.
module cubic_bisection_root_finder_top import cbrf_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [31:0]        left_end,
  input  logic signed [31:0]        right_end,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [31:0]        root,
  output logic [STEP_BITS-1:0]      steps,
  output logic [STATUS_BITS-1:0]    status,
  input  logic                      cfg_we,
  input  logic [REG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EVAL_A = 3'd1;
  localparam logic [2:0] S_EVAL_B = 3'd2;
  localparam logic [2:0] S_CHECK  = 3'd3;
  localparam logic [2:0] S_EVAL_C = 3'd4;
  localparam logic [2:0] S_FINISH = 3'd5;

  coef_t                   coef;
  logic [TOL_BITS-1:0]     tol;
  logic [2:0]              state;
  word_t                   a;
  word_t                   b;
  word_t                   c;
  sign_t                   sa;
  logic [STEP_BITS-1:0]    step_count;
  logic [STATUS_BITS-1:0]  status_val;
  word_t                   root_val;
  logic                    ev_start;
  word_t                   ev_x;
  logic                    ev_done;
  sign_t                   ev_sign;
  logic signed [WORD_BITS:0] diff;
  logic signed [WORD_BITS:0] sum;
  word_t                   mid;
  logic [TOL_BITS-1:0]     tol_eff;
  logic [TOL_BITS:0]       two_tol;
  logic                    narrow;

  cbrf_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .coef      (coef),
    .tol       (tol)
  );

  cbrf_eval u_eval (
    .clk   (clk),
    .rst   (rst),
    .start (ev_start),
    .x     (ev_x),
    .coef  (coef),
    .done  (ev_done),
    .sign  (ev_sign)
  );

  assign in_ready = (state == S_IDLE);
  assign tol_eff  = (tol == '0) ? TOL_BITS'(1) : tol;
  assign two_tol  = {tol_eff, 1'b0};
  assign diff     = {b[WORD_BITS-1], b} - {a[WORD_BITS-1], a};
  assign sum      = {b[WORD_BITS-1], b} + {a[WORD_BITS-1], a};
  assign mid      = sum[WORD_BITS:1];
  assign narrow   = diff[WORD_BITS] || (diff[WORD_BITS-1:0] <= two_tol);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ev_start  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      ev_start <= ((state == S_IDLE) && in_valid) || ((state == S_EVAL_A) && ev_done) ||
                  ((state == S_CHECK) && !narrow);
      if ((state == S_FINISH) && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_EVAL_A;
          end
        end
        S_EVAL_A: begin
          if (ev_done) begin
            state <= S_EVAL_B;
          end
        end
        S_EVAL_B: begin
          if (ev_done) begin
            if (!sa.zero && !ev_sign.zero && (sa.neg == ev_sign.neg)) begin
              state <= S_FINISH;
            end else begin
              state <= S_CHECK;
            end
          end
        end
        S_CHECK: begin
          if (narrow) begin
            state <= S_FINISH;
          end else begin
            state <= S_EVAL_C;
          end
        end
        S_EVAL_C: begin
          if (ev_done) begin
            state <= ev_sign.zero ? S_FINISH : S_CHECK;
          end
        end
        S_FINISH: begin
          if (!out_valid || out_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          a          <= left_end;
          b          <= right_end;
          ev_x       <= left_end;
          step_count <= '0;
        end
      end
      S_EVAL_A: begin
        if (ev_done) begin
          sa   <= ev_sign;
          ev_x <= b;
        end
      end
      S_EVAL_B: begin
        if (ev_done) begin
          root_val   <= '0;
          status_val <= STATUS_NO_CHANGE;
        end
      end
      S_CHECK: begin
        if (narrow) begin
          root_val   <= mid;
          status_val <= STATUS_CONVERGED;
        end else begin
          c          <= mid;
          ev_x       <= mid;
          step_count <= step_count + STEP_BITS'(1);
        end
      end
      S_EVAL_C: begin
        if (ev_done) begin
          if (ev_sign.zero) begin
            root_val   <= c;
            status_val <= STATUS_EXACT;
          end else if (!sa.zero && (sa.neg != ev_sign.neg)) begin
            b <= c;
          end else begin
            a  <= c;
            sa <= ev_sign;
          end
        end
      end
      S_FINISH: begin
        if (!out_valid || out_ready) begin
          root   <= root_val;
          steps  <= step_count;
          status <= status_val;
        end
      end
      default: ;
    endcase
  end

endmodule

[tb/cubic_bisection_root_finder_top_test.sv]
// ----------------------------------------------------------------------------
// cubic_bisection_root_finder_top_test
// Self-checking bench for the cubic bisection root finder. A local model of
// the saturating Horner evaluation and the bisection loop predicts root, step
// count and status for every accepted interval beat. A monitor compares each
// output beat with the oldest prediction. Directed intervals hit the range
// extremes, reversed and degenerate intervals, exact zeros, zeros at an end
// and the tolerance corners. Random phases then reprogram the cubic and the
// tolerance while idle, and drive mostly sign-changing intervals with random
// idle cycles on both sides, one long output stall and a no-idle stretch.
// ----------------------------------------------------------------------------
module cubic_bisection_root_finder_top_test;
  import cbrf_pkg::*;

  localparam int          CLK_HALF    = 1;
  localparam int          RESET_LEN   = 11;
  localparam int          IDLE_MAX    = 9;
  localparam longint      CYCLE_LIMIT = 4_000_000;
  localparam int          TAIL_CYCLES = 400;
  localparam int          LONG_HOLD   = 1500;
  localparam int          MAX_PRINTS  = 100;
  localparam word_t       ONE         = word_t'(1 << FRAC_BITS);
  localparam int          REG_SLOTS   = 1 << REG_INDEX_BITS;

  typedef struct {
    word_t                  root;
    logic [STEP_BITS-1:0]   steps;
    logic [STATUS_BITS-1:0] status;
  } root_result_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  word_t                     left_end = '0;
  word_t                     right_end = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b1;
  word_t                     root;
  logic [STEP_BITS-1:0]      steps;
  logic [STATUS_BITS-1:0]    status;
  logic                      cfg_we = 1'b0;
  logic [REG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

  // register mirror
  coef_t               coef_cfg;
  logic [TOL_BITS-1:0] tol_cfg;

  root_result_t pending_roots[$];
  int unsigned  gap_max = IDLE_MAX;
  int unsigned  stall_max = IDLE_MAX;
  int unsigned  hold_req = 0;
  int unsigned  mismatch_count = 0;
  int unsigned  n_intervals = 0;
  int unsigned  n_converged = 0;
  int unsigned  n_exact = 0;
  int unsigned  n_no_change = 0;
  int unsigned  n_settings = 0;
  longint       cycle_count = 0;

  cubic_bisection_root_finder_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .left_end  (left_end),
    .right_end (right_end),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .root      (root),
    .steps     (steps),
    .status    (status),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_roots.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------- model

  function automatic word_t clamp_word(input longint v);
    if (v > longint'(WORD_MAX)) return WORD_MAX;
    if (v < longint'(WORD_MIN)) return WORD_MIN;
    return word_t'(v);
  endfunction

  // product shifted toward minus infinity, then saturated
  function automatic word_t fix_mul(input word_t p, input word_t q);
    longint prod;
    prod = longint'(p) * longint'(q);
    return clamp_word(prod >>> FRAC_BITS);
  endfunction

  function automatic int cubic_sign(input word_t x);
    word_t acc;
    acc = coef_cfg.cubic;
    acc = clamp_word(longint'(fix_mul(acc, x)) + longint'(coef_cfg.square));
    acc = clamp_word(longint'(fix_mul(acc, x)) + longint'(coef_cfg.linear));
    acc = clamp_word(longint'(fix_mul(acc, x)) + longint'(coef_cfg.cnst));
    return (acc > 0) ? 1 : ((acc < 0) ? -1 : 0);
  endfunction

  function automatic root_result_t predict_root(input word_t l, input word_t r);
    longint       a;
    longint       b;
    longint       c;
    longint       lim;
    int           sa;
    int           sb;
    int           sc;
    root_result_t res;
    a = l;
    b = r;
    lim = 2 * longint'((tol_cfg == '0) ? TOL_BITS'(1) : tol_cfg);
    sa = cubic_sign(l);
    sb = cubic_sign(r);
    res.root = '0;
    res.steps = '0;
    res.status = STATUS_CONVERGED;
    if (sa * sb > 0) begin
      res.status = STATUS_NO_CHANGE;
      return res;
    end
    while (b - a > lim && res.status != STATUS_EXACT) begin
      c = (a + b) >>> 1;
      res.steps++;
      sc = cubic_sign(word_t'(c));
      if (sc == 0) begin
        res.root = word_t'(c);
        res.status = STATUS_EXACT;
      end else if (sa * sc < 0) begin
        b = c;
      end else begin
        a = c;
        sa = sc;
      end
    end
    if (res.status != STATUS_EXACT) res.root = word_t'((a + b) >>> 1);
    return res;
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic flag_error(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTS) $display("mismatch @%0d: %s", cycle_count, msg);
  endtask

  always @(posedge clk) begin
    root_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_roots.size() == 0) begin
        flag_error($sformatf("unexpected beat root=%0d steps=%0d status=%0d",
                             root, steps, status));
      end else begin
        want = pending_roots.pop_front();
        if (root !== want.root)
          flag_error($sformatf("root %0d, expected %0d", root, want.root));
        if (steps !== want.steps)
          flag_error($sformatf("steps %0d, expected %0d", steps, want.steps));
        if (status !== want.status)
          flag_error($sformatf("status %0d, expected %0d", status, want.status));
        case (want.status)
          STATUS_CONVERGED: n_converged++;
          STATUS_EXACT:     n_exact++;
          default:          n_no_change++;
        endcase
      end
    end
  end

  // output side: random stall after each beat, long hold on request
  initial begin
    int unsigned wait_n;
    forever begin
      @(posedge clk);
      if (hold_req != 0) begin
        wait_n = hold_req;
        hold_req = 0;
        out_ready <= 1'b0;
        repeat (wait_n) @(posedge clk);
        out_ready <= 1'b1;
      end else if (out_valid && out_ready) begin
        wait_n = $urandom_range(0, stall_max);
        if (wait_n != 0) begin
          out_ready <= 1'b0;
          repeat (wait_n) @(posedge clk);
          out_ready <= 1'b1;
        end
      end
    end
  end

  // ---------------------------------------------------------------- drivers

  task automatic write_reg(input logic [REG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_COEF_CUBIC:  coef_cfg.cubic = data;
      REG_COEF_SQUARE: coef_cfg.square = data;
      REG_COEF_LINEAR: coef_cfg.linear = data;
      REG_COEF_CONST:  coef_cfg.cnst = data;
      REG_TOLERANCE:   tol_cfg = data[TOL_BITS-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic write_coefs(input word_t c3, input word_t c2, input word_t c1,
                             input word_t c0);
    write_reg(REG_COEF_CUBIC, c3);
    write_reg(REG_COEF_SQUARE, c2);
    write_reg(REG_COEF_LINEAR, c1);
    write_reg(REG_COEF_CONST, c0);
  endtask

  // valid stays up between back-to-back beats; lowered only for a gap or drain
  task automatic send_interval(input word_t l, input word_t r);
    int unsigned gap;
    gap = $urandom_range(0, gap_max);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    left_end <= l;
    right_end <= r;
    do @(posedge clk); while (!in_ready);
    pending_roots.push_back(predict_root(l, r));
    n_intervals++;
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_roots.size() != 0);
  endtask

  function automatic word_t rand_coef;
    case ($urandom_range(0, 5))
      0:       return word_t'($urandom);
      1:       return '0;
      2:       return ($urandom_range(0, 1) != 0) ? WORD_MAX : WORD_MIN;
      default: return word_t'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
    endcase
  endfunction

  function automatic logic [CFG_DATA_BITS-1:0] rand_tolerance;
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return $urandom;
      2:       return {1'b0, {(TOL_BITS){1'b1}}};
      3:       return $urandom_range(256, 1 << 20);
      default: return $urandom_range(1, 255);
    endcase
  endfunction

  // mostly intervals that bracket a sign change, some noise and reversed ends
  function automatic void pick_interval(output word_t l, output word_t r);
    int unsigned kind;
    word_t       mid;
    longint      half;
    kind = $urandom_range(0, 9);
    l = $urandom;
    r = $urandom;
    if (kind < 2) return;
    for (int tries = 0; tries < 16; tries++) begin
      if (kind < 5) begin
        l = {1'b1, 31'($urandom)};
        r = {1'b0, 31'($urandom)};
      end else begin
        mid = (kind < 8) ? word_t'(int'($urandom_range(0, 1 << 25)) - (1 << 24))
                         : word_t'($urandom);
        half = $urandom_range(1, 1 << 20);
        l = clamp_word(longint'(mid) - half);
        r = clamp_word(longint'(mid) + half);
      end
      if (cubic_sign(l) * cubic_sign(r) <= 0) break;
    end
    if (kind == 9) begin
      mid = l;
      l = r;
      r = mid;
    end
  endfunction

  // ---------------------------------------------------------------- tests

  task automatic test_reset_poly;
    send_interval('0, 2 * ONE);
    send_interval(WORD_MIN, WORD_MAX);
    send_interval(WORD_MAX, WORD_MIN);
    send_interval(WORD_MIN, WORD_MIN);
    send_interval(WORD_MAX, WORD_MAX);
    send_interval('0, '0);
    send_interval(-word_t'(1), word_t'(1));
    send_interval(2 * ONE, 3 * ONE);
    send_interval(2 * ONE, '0);
    drain();
  endtask

  // f(x) = x: exact zero at a midpoint and at either end
  task automatic test_exact_zero;
    write_coefs('0, '0, ONE, '0);
    send_interval(-4 * ONE, 4 * ONE);
    send_interval('0, 8 * ONE);
    send_interval(-8 * ONE, '0);
    send_interval(-3 * ONE, 5 * ONE);
    drain();
  endtask

  task automatic test_tolerance_edges;
    write_coefs(ONE, -word_t'(13107), ONE / 2, -ONE);
    write_reg(REG_TOLERANCE, '0);
    send_interval(WORD_MIN, WORD_MAX);
    drain();
    write_reg(REG_TOLERANCE, '1);
    send_interval(WORD_MIN, WORD_MAX);
    drain();
    for (int i = REG_TOLERANCE + 1; i < REG_SLOTS; i++)
      write_reg(REG_INDEX_BITS'(i), $urandom);
    send_interval(-ONE, 4 * ONE);
    drain();
    write_reg(REG_TOLERANCE, 1);
  endtask

  task automatic test_extreme_coefs;
    write_coefs(WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX);
    send_interval(WORD_MIN, WORD_MAX);
    drain();
    write_coefs(WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN);
    send_interval(WORD_MIN, WORD_MAX);
    drain();
    write_coefs(WORD_MIN, WORD_MAX, WORD_MAX, WORD_MAX);
    send_interval(-ONE, ONE);
    drain();
  endtask

  task automatic test_random_settings(input int phases, input int per_phase);
    word_t l;
    word_t r;
    for (int p = 0; p < phases; p++) begin
      if (p != 0) begin
        write_coefs(rand_coef(), rand_coef(), rand_coef(), rand_coef());
        write_reg(REG_TOLERANCE, rand_tolerance());
      end
      n_settings++;
      for (int i = 0; i < per_phase; i++) begin
        pick_interval(l, r);
        send_interval(l, r);
      end
      drain();
    end
  endtask

  // output held off long enough that the block backs up into its input
  task automatic test_output_hold;
    word_t l;
    word_t r;
    write_coefs(ONE, -word_t'(13107), ONE / 2, -ONE);
    write_reg(REG_TOLERANCE, $urandom_range(1, 255));
    hold_req = LONG_HOLD;
    gap_max = 0;
    for (int i = 0; i < 12; i++) begin
      pick_interval(l, r);
      send_interval(l, r);
    end
    gap_max = IDLE_MAX;
    drain();
  endtask

  task automatic test_back_to_back;
    word_t l;
    word_t r;
    gap_max = 0;
    stall_max = 0;
    for (int i = 0; i < 60; i++) begin
      pick_interval(l, r);
      send_interval(l, r);
    end
    drain();
    gap_max = IDLE_MAX;
    stall_max = IDLE_MAX;
  endtask

  initial begin
    coef_cfg.cubic = ONE;
    coef_cfg.square = -word_t'(13107);
    coef_cfg.linear = ONE / 2;
    coef_cfg.cnst = -ONE;
    tol_cfg = 1;
    repeat (RESET_LEN) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_poly();
    test_exact_zero();
    test_tolerance_edges();
    test_extreme_coefs();
    test_random_settings(12, 115);
    test_output_hold();
    test_back_to_back();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_roots.size() != 0)
      flag_error($sformatf("%0d results never arrived", pending_roots.size()));
    $display("%0d intervals over %0d random cubic settings plus directed corners",
             n_intervals, n_settings);
    $display("converged %0d, exact zero %0d, no sign change %0d, mismatches %0d",
             n_converged, n_exact, n_no_change, mismatch_count);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
